@@ hdl/fbc_pkg.sv @@
package fbc_pkg;

  localparam int HALF_W        = 64;
  localparam int ROUND_COUNT_W = 17;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 64;

  localparam int ROTATE_BITS = 7;

  localparam logic [ROUND_COUNT_W-1:0] ROUND_COUNT_RESET = 17'd65536;
  localparam logic [HALF_W-1:0]        ROUND_KEY_RESET   = 64'h73706f3073706f30;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_KEY   = 1'd1;

  typedef struct packed {
    logic load;
    logic step;
    logic xfer;
  } fbc_cmd_t;

  typedef struct packed {
    logic rounds_done;
  } fbc_sts_t;

  function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] x);
    localparam int Amt = ROTATE_BITS % HALF_W;
    logic [HALF_W-1:0] res;
    if (Amt == 0) begin
      res = x;
    end else begin
      res = (x << Amt) | (x >> (HALF_W - Amt));
    end
    return res;
  endfunction

endpackage

@@ hdl/fbc_datapath.sv @@
module fbc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [fbc_pkg::HALF_W-1:0]        in_first_half,
  input  logic [fbc_pkg::HALF_W-1:0]        in_second_half,
  input  logic                              in_last_of_page,
  input  fbc_pkg::fbc_cmd_t                 cmd,
  output fbc_pkg::fbc_sts_t                 sts,
  output logic [fbc_pkg::HALF_W-1:0]        out_first_half,
  output logic [fbc_pkg::HALF_W-1:0]        out_second_half,
  output logic                              out_page_end
);
  import fbc_pkg::*;

  logic [ROUND_COUNT_W-1:0] round_count_r;
  logic [HALF_W-1:0]        round_key_r;
  logic [HALF_W-1:0]        left_r;
  logic [HALF_W-1:0]        right_r;
  logic                     mark_r;
  logic [ROUND_COUNT_W-1:0] remain_r;
  logic [HALF_W-1:0]        out_first_r;
  logic [HALF_W-1:0]        out_second_r;
  logic                     out_mark_r;
  logic [HALF_W-1:0]        round_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= ROUND_COUNT_RESET;
      round_key_r   <= ROUND_KEY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROUND_COUNT: round_count_r <= cfg_data[ROUND_COUNT_W-1:0];
        REG_ROUND_KEY:   round_key_r   <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  assign round_f = left_r ^ rotl(right_r ^ round_key_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r   <= in_first_half;
      right_r  <= in_second_half;
      mark_r   <= in_last_of_page;
      remain_r <= round_count_r;
    end else if (cmd.step) begin
      right_r  <= round_f;
      left_r   <= right_r;
      remain_r <= remain_r - ROUND_COUNT_W'(1);
    end
  end

  // closing swap happens here
  always_ff @(posedge clk) begin
    if (cmd.xfer) begin
      out_first_r  <= right_r;
      out_second_r <= left_r;
      out_mark_r   <= mark_r;
    end
  end

  assign sts.rounds_done = (remain_r == '0);
  assign out_first_half  = out_first_r;
  assign out_second_half = out_second_r;
  assign out_page_end    = out_mark_r;

endmodule

@@ hdl/fbc_ctrl.sv @@
module fbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fbc_pkg::fbc_sts_t  sts,
  output fbc_pkg::fbc_cmd_t  cmd
);
  import fbc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // output slot is free if empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.rounds_done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.xfer  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.xfer) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/feistel_block_cipher_core.sv @@
// 128-bit feistel block transform, encrypt and decrypt are the same operation.
// input channel: in_valid / in_stall with in_first_half (left, bytes 0-7),
//   in_second_half (right, bytes 8-15) and in_last_of_page.
// result channel: out_valid / out_stall with out_first_half (final right),
//   out_second_half (final left) and out_page_end.
// an item moves when valid is high and stall is low at a rising clock edge.
// config: cfg_we writes cfg_data into register cfg_index (0 round count,
//   1 round key); write only while the block is idle.
// one item is in flight at a time: it runs one round per cycle in a single
//   round unit, then moves to the output register once that is free; a new
//   item is taken only after the previous one has left the round unit.
// the result sits in an output register; a stalled receiver holds it there
//   while the next item is accepted and processed, and that item waits in
//   the round unit until the output register frees up.
// reset (synchronous, active low) empties the block and restores
//   round count 65536 and the default round key.
module feistel_block_cipher_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fbc_pkg::HALF_W-1:0]       in_first_half,
  input  logic [fbc_pkg::HALF_W-1:0]       in_second_half,
  input  logic                             in_last_of_page,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fbc_pkg::HALF_W-1:0]       out_first_half,
  output logic [fbc_pkg::HALF_W-1:0]       out_second_half,
  output logic                             out_page_end
);
  import fbc_pkg::*;

  fbc_cmd_t cmd;
  fbc_sts_t sts;

  fbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_first_half   (in_first_half),
    .in_second_half  (in_second_half),
    .in_last_of_page (in_last_of_page),
    .cmd             (cmd),
    .sts             (sts),
    .out_first_half  (out_first_half),
    .out_second_half (out_second_half),
    .out_page_end    (out_page_end)
  );

endmodule
